>>> rtl/bytecode_image_validator_defines.svh
// ---------------------------------------------------------------------------
// Bytecode image validator: assertion macros
// Shared checking macros for the validator RTL.
// ---------------------------------------------------------------------------
`ifndef BYTECODE_IMAGE_VALIDATOR_DEFINES_SVH
`define BYTECODE_IMAGE_VALIDATOR_DEFINES_SVH

// Implication checked in the same cycle.
`define BCIV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the cycle after the antecedent.
`define BCIV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/bciv_pkg.sv
// ---------------------------------------------------------------------------
// Bytecode image validator package
// Status codes, register indexes, header layout and the result type.
// ---------------------------------------------------------------------------
`default_nettype none

package bciv_pkg;

   localparam int HEADER_BYTES = 28;
   localparam int HEADER_WORDS = HEADER_BYTES / 4;
   localparam int WORD_IDX_W   = $clog2(HEADER_WORDS);
   localparam int COUNT_W      = 33;
   localparam int NEED_W       = 35;
   localparam int CSR_ADDR_W   = 2;
   localparam int CSR_DATA_W   = 32;
   localparam int RSP_BITS     = 3 + 4 * 32;
   localparam int RSP_DATA_W   = ((RSP_BITS + 7) / 8) * 8;

   typedef logic [2:0] status_type;

   localparam status_type STATUS_OK       = 3'd0;
   localparam status_type STATUS_SHORT    = 3'd1;
   localparam status_type STATUS_MAGIC    = 3'd2;
   localparam status_type STATUS_VERSION  = 3'd3;
   localparam status_type STATUS_EMPTY    = 3'd4;
   localparam status_type STATUS_TRUNC    = 3'd5;
   localparam status_type STATUS_CHECKSUM = 3'd6;

   localparam logic [CSR_ADDR_W-1:0] CSR_MAGIC = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAJOR = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MINOR = 2'd2;

   localparam logic [31:0] MAGIC_RESET = 32'h434E_4C4E;
   localparam logic [15:0] MAJOR_RESET = 16'd1;
   localparam logic [15:0] MINOR_RESET = 16'd0;

   // Header word positions
   localparam logic [WORD_IDX_W-1:0] W_MAGIC   = 3'd0;
   localparam logic [WORD_IDX_W-1:0] W_VERSION = 3'd1;
   localparam logic [WORD_IDX_W-1:0] W_CODE    = 3'd2;
   localparam logic [WORD_IDX_W-1:0] W_DATA    = 3'd3;
   localparam logic [WORD_IDX_W-1:0] W_POOL    = 3'd4;
   localparam logic [WORD_IDX_W-1:0] W_ENTRY   = 3'd5;
   localparam logic [WORD_IDX_W-1:0] W_CSUM    = 3'd6;

   typedef struct packed {
      logic [31:0] entry_offset;
      logic [31:0] pool_bytes;
      logic [31:0] data_bytes;
      logic [31:0] code_bytes;
      status_type  status;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/bytecode_image_validator.sv
// ---------------------------------------------------------------------------
// Bytecode image validator
// Captures the 28-byte header of a byte-serial image, folds the body into a
// rotate-xor checksum and reports one status item per image.
// ---------------------------------------------------------------------------
//  Channel | Dir | Handshake          | Payload
//  req_    | in  | tvalid / tready    | tdata: image_byte; tlast: final_byte
//  rsp_    | out | tvalid / tready    | tdata: status, code, data, pool, entry
//  csr_    | in  | we (no wait)       | addr: register index; wdata: value
//
//  One byte is taken every cycle while req_tready is high; the byte state
//  updates in the accepting cycle and the final byte's result is registered
//  for the next cycle. The result register decouples the sides: bytes keep
//  flowing while a result is taken, and input stalls only while a result
//  waits unread. Synchronous active-high reset restores the registers and
//  clears the byte count, header words and checksum.
// ---------------------------------------------------------------------------
`default_nettype none
`include "bytecode_image_validator_defines.svh"

module bytecode_image_validator (
   input  wire                               clock,
   input  wire                               reset,
   // image_byte[7:0]
   input  wire  [7:0]                        req_tdata,
   input  wire                               req_tlast,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   // status[2:0], code_bytes[34:3], data_bytes[66:35], pool_bytes[98:67],
   // entry_offset[130:99], zero fill above
   output logic [bciv_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   input  wire                               csr_we,
   input  wire  [bciv_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire  [bciv_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bciv_pkg::*;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [COUNT_W-1:0] HDR_COUNT = COUNT_W'(HEADER_BYTES);

   logic [31:0]        magic_ff;
   logic [15:0]        major_ff;
   logic [15:0]        minor_ff;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [31:0]        hdr_ff [HEADER_WORDS];
   logic [31:0]        hdr_in [HEADER_WORDS];
   logic [31:0]        sum_ff, sum_in;

   logic               rsp_valid_ff;
   rsp_type            rsp_ff, rsp_in;

   logic               take;
   logic               in_header;
   logic [NEED_W-1:0]  need;
   status_type         status;

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign take       = req_tvalid & req_tready;
   assign in_header  = count_ff < HDR_COUNT;

   // Stream state after this byte
   always_comb begin
      for (int w = 0; w < HEADER_WORDS; w++) begin
         hdr_in[w] = hdr_ff[w];
      end
      sum_in = sum_ff;
      if (in_header) begin
         hdr_in[count_ff[WORD_IDX_W+1:2]][count_ff[1:0]*8 +: 8] = req_tdata;
      end else begin
         sum_in = {sum_ff[28:0], sum_ff[31:29]} ^ {24'd0, req_tdata};
      end
      count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
   end

   // Judge the image on its final byte, first failing check wins
   always_comb begin
      need = NEED_W'(HEADER_BYTES) + NEED_W'(hdr_in[W_CODE])
           + NEED_W'(hdr_in[W_DATA]) + NEED_W'(hdr_in[W_POOL]);
      if (count_in < HDR_COUNT) begin
         status = STATUS_SHORT;
      end else if (hdr_in[W_MAGIC] != magic_ff) begin
         status = STATUS_MAGIC;
      end else if (hdr_in[W_VERSION][15:0] != major_ff ||
                   hdr_in[W_VERSION][31:16] > minor_ff) begin
         status = STATUS_VERSION;
      end else if (hdr_in[W_CODE] == 32'd0) begin
         status = STATUS_EMPTY;
      end else if (NEED_W'(count_in) < need) begin
         status = STATUS_TRUNC;
      end else if (sum_in != hdr_in[W_CSUM]) begin
         status = STATUS_CHECKSUM;
      end else begin
         status = STATUS_OK;
      end
      rsp_in.status = status;
      if (status == STATUS_SHORT) begin
         rsp_in.code_bytes   = 32'd0;
         rsp_in.data_bytes   = 32'd0;
         rsp_in.pool_bytes   = 32'd0;
         rsp_in.entry_offset = 32'd0;
      end else begin
         rsp_in.code_bytes   = hdr_in[W_CODE];
         rsp_in.data_bytes   = hdr_in[W_DATA];
         rsp_in.pool_bytes   = hdr_in[W_POOL];
         rsp_in.entry_offset = hdr_in[W_ENTRY];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff <= MAGIC_RESET;
         major_ff <= MAJOR_RESET;
         minor_ff <= MINOR_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_MAGIC: magic_ff <= csr_wdata;
            CSR_MAJOR: major_ff <= csr_wdata[15:0];
            CSR_MINOR: minor_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         for (int w = 0; w < HEADER_WORDS; w++) begin
            hdr_ff[w] <= '0;
         end
      end else if (take) begin
         // clear for the next image after its final byte
         if (req_tlast) begin
            count_ff <= '0;
            sum_ff   <= '0;
            for (int w = 0; w < HEADER_WORDS; w++) begin
               hdr_ff[w] <= '0;
            end
         end else begin
            count_ff <= count_in;
            sum_ff   <= sum_in;
            for (int w = 0; w < HEADER_WORDS; w++) begin
               hdr_ff[w] <= hdr_in[w];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take && req_tlast) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && req_tlast) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_ff);

   `BCIV_ASSERT_NEXT(a_count_step, clock, reset,
      take && !req_tlast && count_ff != COUNT_MAX,
      count_ff == $past(count_ff) + 1'b1, "byte count did not advance")
   `BCIV_ASSERT_NEXT(a_clear_after_last, clock, reset, take && req_tlast,
      count_ff == '0 && sum_ff == '0 && rsp_tvalid, "image end not cleared")
   `BCIV_ASSERT_NOW(a_short_zero, clock, reset,
      rsp_tvalid && rsp_ff.status == STATUS_SHORT,
      rsp_ff.code_bytes == '0 && rsp_ff.entry_offset == '0,
      "short image reports header fields")
   `BCIV_ASSERT_NOW(a_status_range, clock, reset, rsp_tvalid,
      rsp_ff.status != 3'd7, "status code out of range")

endmodule

`default_nettype wire

>>> tb/bytecode_image_validator_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bytecode image validator checker
// Watches the byte, result and register channels of the validator. Keeps its
// own image state, grades each image on its final byte, and compares every
// result item field by field against the oldest pending grade.
// ---------------------------------------------------------------------------

module bytecode_image_validator_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [7:0]                         req_tdata,
   input  logic                               req_tlast,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [bciv_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_we,
   input  logic [bciv_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [bciv_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                 mismatches,
   output int                                 outstanding
);
   import bciv_pkg::*;

   logic [COUNT_W-1:0] byte_count;
   logic [31:0]        hdr_word [HEADER_WORDS];
   logic [31:0]        body_sum;
   logic [31:0]        magic_reg;
   logic [15:0]        major_reg;
   logic [15:0]        minor_reg;
   rsp_type            graded_q [$];

   task automatic clear_image();
      int i;
      byte_count = '0;
      body_sum   = '0;
      for (i = 0; i < HEADER_WORDS; i++) hdr_word[i] = '0;
   endtask

   always @(posedge clock) begin : watch
      rsp_type           got;
      rsp_type           want;
      logic [NEED_W-1:0] need;
      status_type        st;
      if (reset) begin
         clear_image();
         magic_reg  = MAGIC_RESET;
         major_reg  = MAJOR_RESET;
         minor_reg  = MINOR_RESET;
         mismatches = 0;
         graded_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_MAGIC: magic_reg = csr_wdata;
               CSR_MAJOR: major_reg = csr_wdata[15:0];
               CSR_MINOR: minor_reg = csr_wdata[15:0];
               default: ;
            endcase
         end

         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[RSP_BITS-1:0];
            if (graded_q.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: result item with none pending: status %0d code %h",
                           $time, got.status, got.code_bytes);
               mismatches++;
            end else begin
               want = graded_q.pop_front();
               if (got.status !== want.status || got.code_bytes !== want.code_bytes ||
                   got.data_bytes !== want.data_bytes ||
                   got.pool_bytes !== want.pool_bytes ||
                   got.entry_offset !== want.entry_offset ||
                   rsp_tdata[RSP_DATA_W-1:RSP_BITS] !== '0) begin
                  if (mismatches < 10) begin
                     $display("%0t: expected status %0d code %h data %h pool %h entry %h",
                              $time, want.status, want.code_bytes, want.data_bytes,
                              want.pool_bytes, want.entry_offset);
                     $display("%0t:   actual status %0d code %h data %h pool %h entry %h pad %h",
                              $time, got.status, got.code_bytes, got.data_bytes,
                              got.pool_bytes, got.entry_offset,
                              rsp_tdata[RSP_DATA_W-1:RSP_BITS]);
                  end
                  mismatches++;
               end
            end
         end

         if (req_tvalid && req_tready) begin
            // header bytes land little-endian; the rest folds into the sum
            if (byte_count < COUNT_W'(HEADER_BYTES))
               hdr_word[byte_count[4:2]][{byte_count[1:0], 3'b000} +: 8] = req_tdata;
            else
               body_sum = {body_sum[28:0], body_sum[31:29]} ^ {24'd0, req_tdata};
            if (byte_count != {COUNT_W{1'b1}}) byte_count = byte_count + 1'b1;

            if (req_tlast) begin
               // sizes add up without wrap
               need = NEED_W'(HEADER_BYTES) + NEED_W'(hdr_word[W_CODE]) +
                      NEED_W'(hdr_word[W_DATA]) + NEED_W'(hdr_word[W_POOL]);
               if (byte_count < COUNT_W'(HEADER_BYTES))
                  st = STATUS_SHORT;
               else if (hdr_word[W_MAGIC] != magic_reg)
                  st = STATUS_MAGIC;
               else if (hdr_word[W_VERSION][15:0] != major_reg ||
                        hdr_word[W_VERSION][31:16] > minor_reg)
                  st = STATUS_VERSION;
               else if (hdr_word[W_CODE] == '0)
                  st = STATUS_EMPTY;
               else if (NEED_W'(byte_count) < need)
                  st = STATUS_TRUNC;
               else if (body_sum != hdr_word[W_CSUM])
                  st = STATUS_CHECKSUM;
               else
                  st = STATUS_OK;

               want.status = st;
               if (st == STATUS_SHORT) begin
                  want.code_bytes   = '0;
                  want.data_bytes   = '0;
                  want.pool_bytes   = '0;
                  want.entry_offset = '0;
               end else begin
                  want.code_bytes   = hdr_word[W_CODE];
                  want.data_bytes   = hdr_word[W_DATA];
                  want.pool_bytes   = hdr_word[W_POOL];
                  want.entry_offset = hdr_word[W_ENTRY];
               end
               graded_q.push_back(want);
               clear_image();
            end
         end
      end
      outstanding = graded_q.size();
   end

endmodule

>>> tb/bytecode_image_validator_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bytecode image validator testbench
// Streams directed and random bytecode images into the validator under
// several register settings, with random gaps on the byte side and random
// stalls on the result side. The checker grades each image independently.
// ---------------------------------------------------------------------------

module bytecode_image_validator_tb;
   import bciv_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED = 2'd3;

   logic                   clock;
   logic                   reset;
   logic [7:0]             req_tdata;
   logic                   req_tlast;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic                   csr_we;
   logic [CSR_ADDR_W-1:0]  csr_addr;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     mismatches;
   int                     outstanding;

   // register values as last written, used to shape well-formed headers
   logic [31:0]            cfg_magic;
   logic [15:0]            cfg_major;
   logic [15:0]            cfg_minor;
   logic [7:0]             image_q [$];
   int                     phase_bytes;
   int                     phase_images;
   logic                   tx_calm;
   logic                   rx_calm;

   bytecode_image_validator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   bytecode_image_validator_checker image_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // result side: hold off each waiting result for a random number of cycles
   initial begin : drain
      int hold;
      rsp_tready = 1'b0;
      rx_calm    = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) rx_calm = ~rx_calm;
         hold = rx_calm ? 0 : $urandom_range(0, 8);
         if (hold != 0) begin
            rsp_tready <= 1'b0;
            @(posedge clock);
            while (!rsp_tvalid) @(posedge clock);
            repeat (hold) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = tx_calm ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= b;
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_image();
      int i;
      tx_calm = ($urandom_range(0, 3) == 0);
      for (i = 0; i < image_q.size(); i++)
         send_byte(image_q[i], i == image_q.size() - 1);
      phase_bytes += image_q.size();
      phase_images++;
      image_q.delete();
   endtask

   task automatic send_noise(input int len);
      int i;
      for (i = 0; i < len; i++) image_q.push_back(8'($urandom()));
      send_image();
   endtask

   // build a header around a random body; flip corrupts the stored checksum
   task automatic make_image(input logic [31:0] magic, input logic [15:0] major,
                             input logic [15:0] minor, input logic [31:0] code,
                             input logic [31:0] data, input logic [31:0] pool,
                             input logic [31:0] entry, input int body_len,
                             input logic [31:0] flip);
      logic [7:0]  body [$];
      logic [31:0] words [HEADER_WORDS];
      logic [31:0] sum;
      int          i;
      sum = '0;
      for (i = 0; i < body_len; i++) begin
         body.push_back(8'($urandom()));
         sum = {sum[28:0], sum[31:29]} ^ {24'd0, body[i]};
      end
      words[W_MAGIC]   = magic;
      words[W_VERSION] = {minor, major};
      words[W_CODE]    = code;
      words[W_DATA]    = data;
      words[W_POOL]    = pool;
      words[W_ENTRY]   = entry;
      words[W_CSUM]    = sum ^ flip;
      for (i = 0; i < HEADER_BYTES; i++) image_q.push_back(words[i / 4][(i % 4) * 8 +: 8]);
      for (i = 0; i < body_len; i++) image_q.push_back(body[i]);
      send_image();
   endtask

   task automatic random_image();
      logic [31:0] magic;
      logic [31:0] code;
      logic [31:0] data;
      logic [31:0] pool;
      logic [31:0] flip;
      logic [15:0] major;
      logic [15:0] minor;
      int          kind;
      int          span;
      int          body_len;
      magic    = cfg_magic;
      major    = cfg_major;
      minor    = 16'($urandom_range(0, cfg_minor));
      code     = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 8);
      data     = $urandom_range(0, 6);
      pool     = $urandom_range(0, 6);
      span     = code + data + pool;
      body_len = span + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
      flip     = '0;
      kind     = $urandom_range(0, 99);
      if (kind >= 94)
         send_noise($urandom_range(HEADER_BYTES, 45));
      else if (kind >= 88)
         send_noise($urandom_range(1, HEADER_BYTES - 1));
      else begin
         if (kind >= 80)
            flip = $urandom_range(0, 1) ? (32'd1 << $urandom_range(0, 31))
                                        : ($urandom() | 32'd1);
         else if (kind >= 72)
            body_len = $urandom_range(0, span - 1);
         else if (kind >= 67)
            code = '0;
         else if (kind >= 62 && cfg_minor != 16'hFFFF)
            minor = 16'($urandom_range(32'(cfg_minor) + 1, 32'hFFFF));
         else if (kind >= 56)
            major = cfg_major ^ 16'($urandom_range(1, 32'hFFFF));
         else if (kind >= 50)
            magic = cfg_magic ^ ($urandom() | (32'd1 << $urandom_range(0, 31)));
         make_image(magic, major, minor, code, data, pool, $urandom(), body_len, flip);
      end
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [31:0] value);
      csr_addr  <= idx;
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
      case (idx)
         CSR_MAGIC: cfg_magic = value;
         CSR_MAJOR: cfg_major = value[15:0];
         CSR_MINOR: cfg_minor = value[15:0];
         default: ;
      endcase
   endtask

   // drop valid and wait until every graded image has reported
   task automatic settle();
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      int phase;
      reset        = 1'b1;
      req_tdata    = '0;
      req_tlast    = 1'b0;
      req_tvalid   = 1'b0;
      csr_we       = 1'b0;
      csr_addr     = '0;
      csr_wdata    = '0;
      cfg_magic    = MAGIC_RESET;
      cfg_major    = MAJOR_RESET;
      cfg_minor    = MINOR_RESET;
      phase_bytes  = 0;
      phase_images = 0;
      tx_calm      = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // short images: one byte, then one short of a header
      send_noise(1);
      send_noise(HEADER_BYTES - 1);
      // header only with empty code, then bad magic, bad major and too new a minor
      make_image(cfg_magic, cfg_major, 16'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 0, 0);
      make_image(32'hFFFF_FFFF, cfg_major, 16'd0, 32'd1, 32'd0, 32'd0, 32'd0, 1, 0);
      make_image(cfg_magic, 16'd0, 16'd0, 32'd1, 32'd0, 32'd0, 32'd0, 1, 0);
      make_image(cfg_magic, cfg_major, 16'd1, 32'd1, 32'd0, 32'd0, 32'd0, 1, 0);
      // largest sizes, sizes whose 32-bit sum wraps, a valid image and a bad checksum
      make_image(cfg_magic, cfg_major, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 0, 0);
      make_image(cfg_magic, cfg_major, 16'd0, 32'hFFFF_FFF0, 32'h20, 32'd0, 32'd0, 4, 0);
      make_image(cfg_magic, cfg_major, 16'd0, 32'd1, 32'd0, 32'd0, 32'd0, 1, 0);
      make_image(cfg_magic, cfg_major, 16'd0, 32'd4, 32'd2, 32'd2, 32'd7, 8, 32'h8000_0000);
      // trailing bytes beyond the declared sizes
      make_image(cfg_magic, cfg_major, 16'd0, 32'd3, 32'd3, 32'd3, 32'd5, 12, 0);

      for (phase = 0; phase < 5; phase++) begin
         if (phase != 0) begin
            settle();
            if (phase == 1) begin
               write_reg(CSR_MAGIC, 32'hFFFF_FFFF);
               write_reg(CSR_MAJOR, 32'hFFFF_FFFF);
               write_reg(CSR_MINOR, 32'hFFFF_FFFF);
            end else if (phase == 2) begin
               write_reg(CSR_MAGIC, 32'd0);
               write_reg(CSR_MAJOR, 32'd0);
               write_reg(CSR_MINOR, 32'd0);
            end else begin
               // upper junk in the 16-bit registers must be dropped
               write_reg(CSR_UNUSED, $urandom());
               write_reg(CSR_MAGIC, $urandom());
               write_reg(CSR_MAJOR, $urandom());
               write_reg(CSR_MINOR, $urandom_range(0, 1) ? $urandom() : {$urandom_range(0, 15)});
            end
         end
         phase_bytes  = 0;
         phase_images = 0;
         while (phase_bytes < 110 || phase_images < 2) random_image();
      end

      settle();
      if (mismatches == 0 && outstanding == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
